/* hdl/ffs_pkg.sv */
// Shared types, constants and field layout for the flow field statistics block.
`timescale 1ns / 1ps

package ffs_pkg;

    // Fixed-point format and default sizes.
    localparam int FRAC_BITS      = 16;
    localparam int COUNT_BITS_DEF = 20;
    localparam logic [30:0] REF_DENSITY_RESET = 31'd65536;

    // Packed widths of the stream payloads.
    localparam int IN_TDATA_W  = 128;
    localparam int OUT_TDATA_W = 544;

    // Iteration counts of the shared serial units.
    localparam int SQRT_STEPS  = 32;
    localparam int SQRT_ITER_W = $clog2(SQRT_STEPS + 1);
    localparam int DIV_STEPS   = 64;
    localparam int DIV_ITER_W  = $clog2(DIV_STEPS + 1);

    // Accumulator slots behind the shared saturating adder.
    localparam int ACC_N     = 9;
    localparam int ACC_IDX_W = $clog2(ACC_N);
    localparam logic [ACC_IDX_W-1:0] ACC_MX  = 4'd0;
    localparam logic [ACC_IDX_W-1:0] ACC_MY  = 4'd1;
    localparam logic [ACC_IDX_W-1:0] ACC_MZ  = 4'd2;
    localparam logic [ACC_IDX_W-1:0] ACC_MSZ = 4'd3;
    localparam logic [ACC_IDX_W-1:0] ACC_DEN = 4'd4;
    localparam logic [ACC_IDX_W-1:0] ACC_VX  = 4'd5;
    localparam logic [ACC_IDX_W-1:0] ACC_VY  = 4'd6;
    localparam logic [ACC_IDX_W-1:0] ACC_VZ  = 4'd7;
    localparam logic [ACC_IDX_W-1:0] ACC_SPD = 4'd8;

    // Mean slots, in the same order as the accumulators from ACC_VX on.
    localparam int MEAN_N = 4;
    localparam logic [1:0] MEAN_VX    = 2'd0;
    localparam logic [1:0] MEAN_SPEED = 2'd3;

    // Saturation limits.
    localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;
    localparam logic [63:0] U64_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_EMIT
    } ffs_state_t;

    typedef enum logic [3:0] {
        STEP_SQ_X,
        STEP_SQ_Y,
        STEP_SQ_Z,
        STEP_SQ_ADD,
        STEP_MOM_X,
        STEP_MOM_Y,
        STEP_MOM_Z,
        STEP_DEN,
        STEP_VEL_X,
        STEP_VEL_Y,
        STEP_VEL_Z,
        STEP_ROOT_WAIT,
        STEP_MSIZE_MUL,
        STEP_MSIZE,
        STEP_SPEED
    } ffs_step_t;

    typedef enum logic [1:0] {
        SAT_SIGNED,
        SAT_U63,
        SAT_U64
    } ffs_sat_t;

    // Status of a serial arithmetic unit.
    typedef struct packed {
        logic busy;
        logic done;
    } ffs_unit_stat_t;

endpackage

/* hdl/ffs_sqrt.sv */
// Serial integer square root, one result bit per cycle.
`timescale 1ns / 1ps

module ffs_sqrt (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [63:0]             radicand,
    output ffs_pkg::ffs_unit_stat_t stat,
    output logic [31:0]             root
);
    import ffs_pkg::*;

    logic [63:0]            rad_reg;
    logic [33:0]            rem_reg;
    logic [31:0]            root_reg;
    logic [SQRT_ITER_W-1:0] iter_reg;
    logic                   busy_reg;
    logic                   done_reg;

    logic [35:0] rem_sh;
    logic [35:0] trial;
    logic        fits;
    logic [35:0] rem_new;

    // Bring down the next two radicand bits and try the next root bit.
    always_comb
    begin
        rem_sh  = {rem_reg, rad_reg[63:62]};
        trial   = {2'b00, root_reg, 2'b01};
        fits    = (rem_sh >= trial);
        rem_new = fits ? (rem_sh - trial) : rem_sh;
    end

    // Iteration control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                iter_reg <= SQRT_ITER_W'(SQRT_STEPS);
            end
            else if (busy_reg)
            begin
                iter_reg <= iter_reg - SQRT_ITER_W'(1);
                if (iter_reg == SQRT_ITER_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder, root and radicand shift register.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[61:0], 2'b00};
            rem_reg  <= rem_new[33:0];
            root_reg <= {root_reg[30:0], fits};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign root      = root_reg;

endmodule

/* hdl/ffs_div.sv */
// Serial restoring divider of a 64-bit magnitude by the node count.
`timescale 1ns / 1ps

module ffs_div #(
    parameter int COUNT_BITS = ffs_pkg::COUNT_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [63:0]             dividend,
    input  logic [COUNT_BITS:0]     divisor,
    output ffs_pkg::ffs_unit_stat_t stat,
    output logic [63:0]             quotient
);
    import ffs_pkg::*;

    logic [63:0]           quot_reg;
    logic [COUNT_BITS:0]   rem_reg;
    logic [DIV_ITER_W-1:0] iter_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [COUNT_BITS+1:0] rem_sh;
    logic [COUNT_BITS+1:0] dvs;
    logic                  fits;
    logic [COUNT_BITS+1:0] rem_new;

    // One quotient bit per cycle.
    always_comb
    begin
        rem_sh  = {rem_reg, quot_reg[63]};
        dvs     = {1'b0, divisor};
        fits    = (rem_sh >= dvs);
        rem_new = fits ? (rem_sh - dvs) : rem_sh;
    end

    // Iteration control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                iter_reg <= DIV_ITER_W'(DIV_STEPS);
            end
            else if (busy_reg)
            begin
                iter_reg <= iter_reg - DIV_ITER_W'(1);
                if (iter_reg == DIV_ITER_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // The dividend shifts out as the quotient shifts in.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            quot_reg <= {quot_reg[62:0], fits};
            rem_reg  <= rem_new[COUNT_BITS:0];
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quot_reg;

endmodule

/* hdl/flow_field_statistics_core.sv */
// Top level: node sequencer, shared multiplier and saturating adder, result register.
`timescale 1ns / 1ps
// Sequence: after a node is accepted s_tready stays low while the multiplier forms the squares,
// the square root runs beside the momentum, density and velocity sums, the root is awaited, and
// momentum size and speed are added; only then is a new node taken. A node marked last adds four
// serial divisions for the means and the loading of the result once the output register is free.
// Reset (asynchronous, active low) clears all sums and the count, sets the reference
// density to 1.0 and empties the output register.

module flow_field_statistics_core #(
    parameter int COUNT_BITS = ffs_pkg::COUNT_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wen,
    input  logic [30:0]                    cfg_wdata,  // reference_density
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // density[30:0], velocity_x[62:31], velocity_y[94:63], velocity_z[126:95], pad
    input  logic [ffs_pkg::IN_TDATA_W-1:0] s_tdata,
    input  logic                           s_tlast,    // last_node
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // total_momentum_x[63:0], total_momentum_y[127:64], total_momentum_z[191:128],
    // total_momentum_size[254:192], total_density[317:255], mean_velocity_x[349:318],
    // mean_velocity_y[381:350], mean_velocity_z[413:382], mean_speed[445:414],
    // largest_density[476:446], smallest_density[507:477], largest_speed[539:508], pad
    output logic [ffs_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import ffs_pkg::*;

    ffs_state_t state_reg, state_next;
    ffs_step_t  step_reg, step_next;
    logic [1:0] div_idx_reg, div_idx_next;

    logic [30:0]         ref_reg;
    logic [30:0]         den_reg;
    logic [31:0]         vel_reg [3];
    logic [31:0]         mag_reg [3];
    logic                last_reg;
    logic [COUNT_BITS:0] count_reg;
    logic [63:0]         acc_reg [ACC_N];
    logic [63:0]         sq_reg;
    logic [63:0]         prod_reg;
    logic [30:0]         max_den_reg;
    logic [30:0]         min_den_reg;
    logic [31:0]         max_spd_reg;
    logic [31:0]         mean_reg [MEAN_N];
    logic                m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;

    logic accept;

    // Sequencer outputs.
    logic                 sqrt_start;
    logic                 div_start;
    logic                 acc_en;
    logic [ACC_IDX_W-1:0] acc_idx;
    logic [63:0]          acc_b;
    ffs_sat_t             acc_mode;
    logic [31:0]          mul_a;
    logic [31:0]          mul_b;
    logic                 sq_first;
    logic                 sq_en;
    logic                 den_upd;
    logic                 spd_upd;
    logic                 mean_load;
    logic                 out_load;

    // Shared datapath signals.
    logic [63:0]    acc_a;
    logic [64:0]    acc_wide;
    logic [63:0]    acc_sum;
    logic [63:0]    mom_mag;
    logic [63:0]    mom_val;
    logic [1:0]     mom_sel;
    logic           div_neg;
    logic [63:0]    div_dividend;
    logic [63:0]    div_quot;
    logic [31:0]    mean_val;
    logic [31:0]    root;
    ffs_unit_stat_t sqrt_stat;
    ffs_unit_stat_t div_stat;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Sequencer: next state and datapath controls.
    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        div_idx_next = div_idx_reg;
        sqrt_start   = 1'b0;
        div_start    = 1'b0;
        acc_en       = 1'b0;
        acc_idx      = ACC_MX;
        acc_mode     = SAT_SIGNED;
        mul_a        = '0;
        mul_b        = '0;
        sq_first     = 1'b0;
        sq_en        = 1'b0;
        den_upd      = 1'b0;
        spd_upd      = 1'b0;
        mean_load    = 1'b0;
        out_load     = 1'b0;
        mom_sel      = 2'd0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_RUN;
                    step_next  = STEP_SQ_X;
                end
            end
            ST_RUN:
            begin
                unique case (step_reg)
                    STEP_SQ_X:
                    begin
                        mul_a     = mag_reg[0];
                        mul_b     = mag_reg[0];
                        step_next = STEP_SQ_Y;
                    end
                    STEP_SQ_Y:
                    begin
                        mul_a     = mag_reg[1];
                        mul_b     = mag_reg[1];
                        sq_en     = 1'b1;
                        sq_first  = 1'b1;
                        step_next = STEP_SQ_Z;
                    end
                    STEP_SQ_Z:
                    begin
                        mul_a     = mag_reg[2];
                        mul_b     = mag_reg[2];
                        sq_en     = 1'b1;
                        step_next = STEP_SQ_ADD;
                    end
                    STEP_SQ_ADD:
                    begin
                        mul_a     = {1'b0, den_reg};
                        mul_b     = mag_reg[0];
                        sq_en     = 1'b1;
                        step_next = STEP_MOM_X;
                    end
                    STEP_MOM_X:
                    begin
                        sqrt_start = 1'b1;
                        mul_a      = {1'b0, den_reg};
                        mul_b      = mag_reg[1];
                        acc_en     = 1'b1;
                        acc_idx    = ACC_MX;
                        mom_sel    = 2'd0;
                        step_next  = STEP_MOM_Y;
                    end
                    STEP_MOM_Y:
                    begin
                        mul_a     = {1'b0, den_reg};
                        mul_b     = mag_reg[2];
                        acc_en    = 1'b1;
                        acc_idx   = ACC_MY;
                        mom_sel   = 2'd1;
                        step_next = STEP_MOM_Z;
                    end
                    STEP_MOM_Z:
                    begin
                        acc_en    = 1'b1;
                        acc_idx   = ACC_MZ;
                        mom_sel   = 2'd2;
                        step_next = STEP_DEN;
                    end
                    STEP_DEN:
                    begin
                        acc_en    = 1'b1;
                        acc_idx   = ACC_DEN;
                        acc_mode  = SAT_U63;
                        den_upd   = 1'b1;
                        step_next = STEP_VEL_X;
                    end
                    STEP_VEL_X:
                    begin
                        acc_en    = 1'b1;
                        acc_idx   = ACC_VX;
                        step_next = STEP_VEL_Y;
                    end
                    STEP_VEL_Y:
                    begin
                        acc_en    = 1'b1;
                        acc_idx   = ACC_VY;
                        step_next = STEP_VEL_Z;
                    end
                    STEP_VEL_Z:
                    begin
                        acc_en    = 1'b1;
                        acc_idx   = ACC_VZ;
                        step_next = STEP_ROOT_WAIT;
                    end
                    STEP_ROOT_WAIT:
                    begin
                        if (!sqrt_stat.busy)
                        begin
                            step_next = STEP_MSIZE_MUL;
                        end
                    end
                    STEP_MSIZE_MUL:
                    begin
                        mul_a     = {1'b0, den_reg};
                        mul_b     = root;
                        step_next = STEP_MSIZE;
                    end
                    STEP_MSIZE:
                    begin
                        acc_en    = 1'b1;
                        acc_idx   = ACC_MSZ;
                        acc_mode  = SAT_U63;
                        step_next = STEP_SPEED;
                    end
                    STEP_SPEED:
                    begin
                        acc_en       = 1'b1;
                        acc_idx      = ACC_SPD;
                        acc_mode     = SAT_U64;
                        spd_upd      = 1'b1;
                        div_idx_next = MEAN_VX;
                        state_next   = last_reg ? ST_DIV_START : ST_IDLE;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_DIV_START:
            begin
                acc_idx    = ACC_VX + {2'b00, div_idx_reg};
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                acc_idx = ACC_VX + {2'b00, div_idx_reg};
                if (div_stat.done)
                begin
                    mean_load = 1'b1;
                    if (div_idx_reg == MEAN_SPEED)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        div_idx_next = div_idx_reg + 2'd1;
                        state_next   = ST_DIV_START;
                    end
                end
            end
            ST_EMIT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Signed momentum term from the registered product of density and speed component.
    always_comb
    begin
        mom_mag = prod_reg >> FRAC_BITS;
        mom_val = vel_reg[mom_sel][31] ? (64'd0 - mom_mag) : mom_mag;
    end

    // Addend for the accumulator picked by the sequencer.
    always_comb
    begin
        unique case (acc_idx)
            ACC_MX, ACC_MY, ACC_MZ: acc_b = mom_val;
            ACC_MSZ:                acc_b = prod_reg >> FRAC_BITS;
            ACC_DEN:                acc_b = {33'd0, den_reg};
            ACC_VX:                 acc_b = {{32{vel_reg[0][31]}}, vel_reg[0]};
            ACC_VY:                 acc_b = {{32{vel_reg[1][31]}}, vel_reg[1]};
            ACC_VZ:                 acc_b = {{32{vel_reg[2][31]}}, vel_reg[2]};
            ACC_SPD:                acc_b = {32'd0, root};
            default:                acc_b = '0;
        endcase
    end

    // Shared saturating adder.
    always_comb
    begin
        acc_a = acc_reg[acc_idx];
        if (acc_mode == SAT_SIGNED)
        begin
            acc_wide = {acc_a[63], acc_a} + {acc_b[63], acc_b};
        end
        else
        begin
            acc_wide = {1'b0, acc_a} + {1'b0, acc_b};
        end
        unique case (acc_mode)
            SAT_SIGNED:
            begin
                if (acc_wide[64] != acc_wide[63])
                begin
                    acc_sum = acc_wide[64] ? S64_MIN : S64_MAX;
                end
                else
                begin
                    acc_sum = acc_wide[63:0];
                end
            end
            SAT_U63:
            begin
                acc_sum = (acc_wide[64] || acc_wide[63]) ? S64_MAX : acc_wide[63:0];
            end
            SAT_U64:
            begin
                acc_sum = acc_wide[64] ? U64_MAX : acc_wide[63:0];
            end
            default:
            begin
                acc_sum = acc_wide[63:0];
            end
        endcase
    end

    // Divider operand and clamping of the quotient to the mean field.
    always_comb
    begin
        div_neg      = (div_idx_reg != MEAN_SPEED) && acc_a[63];
        div_dividend = div_neg ? (64'd0 - acc_a) : acc_a;
        if (div_idx_reg == MEAN_SPEED)
        begin
            mean_val = (|div_quot[63:32]) ? 32'hFFFF_FFFF : div_quot[31:0];
        end
        else if (!div_neg)
        begin
            mean_val = (|div_quot[63:31]) ? 32'h7FFF_FFFF : div_quot[31:0];
        end
        else if ((|div_quot[63:32]) || (div_quot[31] && (|div_quot[30:0])))
        begin
            mean_val = 32'h8000_0000;
        end
        else
        begin
            mean_val = 32'd0 - div_quot[31:0];
        end
    end

    ffs_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sq_reg),
        .stat     (sqrt_stat),
        .root     (root)
    );

    ffs_div #(
        .COUNT_BITS (COUNT_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (count_reg),
        .stat     (div_stat),
        .quotient (div_quot)
    );

    // Control state and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            step_reg     <= STEP_SQ_X;
            div_idx_reg  <= MEAN_VX;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            div_idx_reg <= div_idx_next;
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Set state: reference register, sums, extremes and node count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_reg     <= REF_DENSITY_RESET;
            count_reg   <= '0;
            max_den_reg <= REF_DENSITY_RESET;
            min_den_reg <= REF_DENSITY_RESET;
            max_spd_reg <= '0;
            for (int i = 0; i < ACC_N; i++)
            begin
                acc_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_wen)
            begin
                ref_reg <= cfg_wdata;
            end
            // The first node of a set reseeds the extremes from the current reference.
            if (accept && (count_reg == '0))
            begin
                max_den_reg <= ref_reg;
                min_den_reg <= ref_reg;
                max_spd_reg <= '0;
            end
            if (acc_en)
            begin
                acc_reg[acc_idx] <= acc_sum;
            end
            if (den_upd)
            begin
                if (den_reg > max_den_reg)
                begin
                    max_den_reg <= den_reg;
                end
                if (den_reg < min_den_reg)
                begin
                    min_den_reg <= den_reg;
                end
            end
            if (spd_upd)
            begin
                if (root > max_spd_reg)
                begin
                    max_spd_reg <= root;
                end
                if (!(&count_reg))
                begin
                    count_reg <= count_reg + {{COUNT_BITS{1'b0}}, 1'b1};
                end
            end
            // Clear for the next set once the result is loaded into the output register.
            if (out_load)
            begin
                count_reg   <= '0;
                max_den_reg <= ref_reg;
                min_den_reg <= ref_reg;
                max_spd_reg <= '0;
                for (int i = 0; i < ACC_N; i++)
                begin
                    acc_reg[i] <= '0;
                end
            end
        end
    end

    // Item capture, multiplier, sum of squares, means and result register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            den_reg  <= s_tdata[30:0];
            last_reg <= s_tlast;
            for (int i = 0; i < 3; i++)
            begin
                vel_reg[i] <= s_tdata[31 + 32*i +: 32];
                mag_reg[i] <= s_tdata[62 + 32*i] ? (32'd0 - s_tdata[31 + 32*i +: 32])
                                                 : s_tdata[31 + 32*i +: 32];
            end
        end
        prod_reg <= mul_a * mul_b;
        if (sq_en)
        begin
            sq_reg <= (sq_first ? 64'd0 : sq_reg) + prod_reg;
        end
        if (mean_load)
        begin
            mean_reg[div_idx_reg] <= mean_val;
        end
        if (out_load)
        begin
            m_tdata_reg <= {4'd0, max_spd_reg, min_den_reg, max_den_reg,
                            mean_reg[3], mean_reg[2], mean_reg[1], mean_reg[0],
                            acc_reg[ACC_DEN][62:0], acc_reg[ACC_MSZ][62:0],
                            acc_reg[ACC_MZ], acc_reg[ACC_MY], acc_reg[ACC_MX]};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

/* hdl/ffs_checker.sv */
// Port-level checks for the flow field statistics block and their binding.
`timescale 1ns / 1ps

module ffs_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [ffs_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import ffs_pkg::*;

    // A stalled result holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // An accepted node keeps the block busy, with s_tready low.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
        else $error("input ready too soon after a node");

    // A fresh result appears only as the block leaves its busy phase.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> s_tready && $past(!s_tready))
        else $error("result appeared outside the end of a set");

    // Largest density never falls below smallest density.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[476:446] >= m_tdata[507:477]))
        else $error("density extremes out of order");

endmodule

bind flow_field_statistics_core ffs_checker u_ffs_checker (.*);

/* tb/ffs_stats_checker.sv */
// Checker that predicts and compares the per-set results of the flow field statistics core.
`timescale 1ns / 1ps

module ffs_stats_checker #(
    parameter int COUNT_BITS = ffs_pkg::COUNT_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wen,
    input  logic [30:0]                     cfg_wdata,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [ffs_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic                            s_tlast,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [ffs_pkg::OUT_TDATA_W-1:0] m_tdata,
    output int                              fail_count,
    output int                              pending_results
);

    // One set result, laid out so that it matches the low bits of m_tdata.
    typedef struct packed {
        logic [31:0] speed_max;
        logic [30:0] den_min;
        logic [30:0] den_max;
        logic [31:0] mean_speed;
        logic [31:0] mean_vz;
        logic [31:0] mean_vy;
        logic [31:0] mean_vx;
        logic [62:0] den_total;
        logic [62:0] mom_size;
        logic [63:0] mom_z;
        logic [63:0] mom_y;
        logic [63:0] mom_x;
    } set_result_t;

    // Predicted block state.
    logic [30:0]         ref_density;
    logic [63:0]         den_total;
    logic [63:0]         speed_total;
    logic [63:0]         msize_total;
    longint              vel_total [3];
    longint              mom_total [3];
    logic [30:0]         den_hi;
    logic [30:0]         den_lo;
    logic [31:0]         speed_hi;
    logic [COUNT_BITS:0] nodes;

    set_result_t stats_expected [$];
    int          sets_checked;

    task automatic report_failure(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        fail_count++;
    endtask

    // Floor of the square root, one result bit per step.
    function automatic logic [31:0] root_floor(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] one_bit;
        rem = v;
        res = '0;
        one_bit = 64'h1 << 62;
        while (one_bit > rem)
            one_bit = one_bit >> 2;
        while (one_bit != 0)
        begin
            if (rem >= res + one_bit)
            begin
                rem = rem - (res + one_bit);
                res = (res >> 1) + one_bit;
            end
            else
                res = res >> 1;
            one_bit = one_bit >> 2;
        end
        return res[31:0];
    endfunction

    // Signed 64-bit add that clamps at the range ends.
    function automatic longint add_clamped(input longint a, input longint b);
        longint s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63])
            s = a[63] ? ffs_pkg::S64_MIN : ffs_pkg::S64_MAX;
        return s;
    endfunction

    // Unsigned add that stops at the given ceiling.
    function automatic logic [63:0] add_capped(input logic [63:0] a, input logic [63:0] b,
                                               input logic [63:0] ceiling);
        logic [64:0] s;
        if (a > ceiling)
            a = ceiling;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, ceiling}) ? ceiling : s[63:0];
    endfunction

    // Mean truncated toward zero and clamped to 32 signed bits.
    function automatic logic [31:0] mean_of(input longint total, input longint cnt);
        longint q;
        q = total / cnt;
        if (q > 64'sd2147483647)
            q = 64'sd2147483647;
        if (q < -64'sd2147483648)
            q = -64'sd2147483648;
        return q[31:0];
    endfunction

    task automatic clear_set();
        int i;
        den_total   = '0;
        speed_total = '0;
        msize_total = '0;
        for (i = 0; i < 3; i++)
        begin
            vel_total[i] = 0;
            mom_total[i] = 0;
        end
        den_hi   = ref_density;
        den_lo   = ref_density;
        speed_hi = '0;
        nodes    = '0;
    endtask

    // Take in one node; on the last node of a set, queue the predicted result.
    task automatic absorb_node(input logic [ffs_pkg::IN_TDATA_W-1:0] d, input logic last);
        logic [30:0] den;
        logic [31:0] vel [3];
        logic [31:0] mag;
        logic [63:0] sq;
        logic [63:0] mom_mag;
        logic [63:0] q;
        logic [31:0] speed;
        longint      mom;
        set_result_t r;
        int          i;
        den    = d[30:0];
        vel[0] = d[62:31];
        vel[1] = d[94:63];
        vel[2] = d[126:95];

        // A new set starts from the current reference density.
        if (nodes == 0)
        begin
            den_hi   = ref_density;
            den_lo   = ref_density;
            speed_hi = '0;
        end

        sq = '0;
        for (i = 0; i < 3; i++)
        begin
            mag     = vel[i][31] ? -vel[i] : vel[i];
            sq      = sq + 64'(mag) * 64'(mag);
            mom_mag = (64'(den) * 64'(mag)) >> ffs_pkg::FRAC_BITS;
            mom     = vel[i][31] ? -longint'(mom_mag) : longint'(mom_mag);
            mom_total[i] = add_clamped(mom_total[i], mom);
            vel_total[i] = add_clamped(vel_total[i], longint'(signed'(vel[i])));
        end
        speed = root_floor(sq);

        den_total   = add_capped(den_total, 64'(den), ffs_pkg::S64_MAX);
        speed_total = add_capped(speed_total, 64'(speed), ffs_pkg::U64_MAX);
        msize_total = add_capped(msize_total,
                                 (64'(den) * 64'(speed)) >> ffs_pkg::FRAC_BITS,
                                 ffs_pkg::S64_MAX);
        if (den > den_hi)
            den_hi = den;
        if (den < den_lo)
            den_lo = den;
        if (speed > speed_hi)
            speed_hi = speed;
        if (nodes != '1)
            nodes++;

        if (last)
        begin
            r.mom_x     = mom_total[0];
            r.mom_y     = mom_total[1];
            r.mom_z     = mom_total[2];
            r.mom_size  = msize_total[62:0];
            r.den_total = den_total[62:0];
            r.mean_vx   = mean_of(vel_total[0], nodes);
            r.mean_vy   = mean_of(vel_total[1], nodes);
            r.mean_vz   = mean_of(vel_total[2], nodes);
            q = speed_total / 64'(nodes);
            r.mean_speed = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
            r.den_max   = den_hi;
            r.den_min   = den_lo;
            r.speed_max = speed_hi;
            stats_expected.push_back(r);
            clear_set();
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_failure($sformatf("result %0d: %s is %h, expected %h",
                                     sets_checked, name, got, want));
    endtask

    task automatic compare_result(input set_result_t got, input set_result_t want);
        check_field("total_momentum_x",    got.mom_x,           want.mom_x);
        check_field("total_momentum_y",    got.mom_y,           want.mom_y);
        check_field("total_momentum_z",    got.mom_z,           want.mom_z);
        check_field("total_momentum_size", 64'(got.mom_size),   64'(want.mom_size));
        check_field("total_density",       64'(got.den_total),  64'(want.den_total));
        check_field("mean_velocity_x",     64'(got.mean_vx),    64'(want.mean_vx));
        check_field("mean_velocity_y",     64'(got.mean_vy),    64'(want.mean_vy));
        check_field("mean_velocity_z",     64'(got.mean_vz),    64'(want.mean_vz));
        check_field("mean_speed",          64'(got.mean_speed), 64'(want.mean_speed));
        check_field("largest_density",     64'(got.den_max),    64'(want.den_max));
        check_field("smallest_density",    64'(got.den_min),    64'(want.den_min));
        check_field("largest_speed",       64'(got.speed_max),  64'(want.speed_max));
        sets_checked++;
    endtask

    // Watch both channels and the register port at each rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_count   = 0;
            sets_checked = 0;
            ref_density  = ffs_pkg::REF_DENSITY_RESET;
            clear_set();
            stats_expected.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (stats_expected.size() == 0)
                    report_failure("result item arrived with no result expected");
                else
                    compare_result(m_tdata[539:0], stats_expected.pop_front());
            end
            if (s_tvalid && s_tready)
                absorb_node(s_tdata, s_tlast);
            if (cfg_wen)
                ref_density = cfg_wdata;
        end
        pending_results = stats_expected.size();
    end

endmodule

/* tb/flow_field_statistics_core_tb.sv */
// Testbench top: clock, reset, node stimulus, output stalls and verdict for the statistics core.
`timescale 1ns / 1ps

module flow_field_statistics_core_tb;

    localparam logic [30:0] DEN_MAX        = 31'h7FFF_FFFF;
    localparam logic [31:0] VEL_MIN        = 32'h8000_0000;
    localparam logic [31:0] VEL_MAX        = 32'h7FFF_FFFF;
    localparam int          ITEM_TARGET    = 650;
    localparam int          HOLD_CYCLES    = 4000;
    localparam int          WATCHDOG_LIMIT = 20000;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_SHUT
    } rx_mode_t;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_wen;
    logic [30:0]                     cfg_wdata;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [ffs_pkg::IN_TDATA_W-1:0]  s_tdata;
    logic                            s_tlast;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [ffs_pkg::OUT_TDATA_W-1:0] m_tdata;

    int fail_count;
    int pending_results;
    int sent_items;
    int burst_left;
    int quiet_cycles;
    bit pressure_go;
    bit pressure_done;

    flow_field_statistics_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    ffs_stats_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wen         (cfg_wen),
        .cfg_wdata       (cfg_wdata),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Gap before a new burst: often none, sometimes short, now and then long.
    function automatic int pick_gap();
        case ($urandom_range(0, 7))
            0, 1, 2, 3: return 0;
            4, 5:       return $urandom_range(1, 8);
            6:          return $urandom_range(9, 60);
            default:    return $urandom_range(61, 150);
        endcase
    endfunction

    function automatic logic [30:0] pick_density();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return DEN_MAX;
            2, 3:    return 31'($urandom_range(0, 262144));
            4:       return 31'd65536;
            default: return 31'($urandom());
        endcase
    endfunction

    function automatic logic [31:0] pick_velocity();
        case ($urandom_range(0, 9))
            0:       return VEL_MIN;
            1:       return VEL_MAX;
            2:       return '0;
            3, 4, 5: return $urandom_range(0, 2097152) - 32'd1048576;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [30:0] pick_reference();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return DEN_MAX;
            2:       return 31'd65536;
            3:       return 31'($urandom_range(0, 262144));
            default: return 31'($urandom());
        endcase
    endfunction

    // Offer one node and hold it until the block takes it. Called at a falling edge.
    task automatic send_node(input logic [30:0] den, input logic [31:0] vx,
                             input logic [31:0] vy, input logic [31:0] vz, input logic last);
        int gap;
        if (burst_left == 0)
        begin
            gap = pick_gap();
            if (gap > 0)
            begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tdata  = {1'b0, vz, vy, vx, den};
        s_tlast  = last;
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        sent_items++;
    endtask

    // Let every queued result drain so the register can be written safely.
    task automatic wait_idle();
        s_tvalid = 1'b0;
        while (pending_results != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    task automatic write_reference(input logic [30:0] value);
        cfg_wen   = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_wen   = 1'b0;
    endtask

    // Output side: stretches of different stall patterns, plus one long hold-off.
    initial
    begin
        rx_mode_t mode;
        int       stretch;
        m_tready = 1'b0;
        mode     = RX_OPEN;
        stretch  = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (pressure_go && !pressure_done)
            begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                pressure_done = 1'b1;
            end
            if (stretch == 0)
            begin
                mode    = rx_mode_t'($urandom_range(0, 3));
                stretch = $urandom_range(20, 300);
            end
            stretch--;
            case (mode)
                RX_OPEN:   m_tready = 1'b1;
                RX_COIN:   m_tready = 1'($urandom_range(0, 1));
                RX_SPARSE: m_tready = ($urandom_range(0, 5) == 0);
                default:   m_tready = 1'b0;
            endcase
        end
    end

    // Ends the run if neither channel moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Stimulus and verdict.
    initial
    begin
        int set_len;
        int n;
        rst_n         = 1'b0;
        cfg_wen       = 1'b0;
        cfg_wdata     = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tlast       = 1'b0;
        sent_items    = 0;
        burst_left    = 0;
        pressure_go   = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset reference density: zero node, then both velocity extremes at full density.
        send_node('0, '0, '0, '0, 1'b1);
        send_node(DEN_MAX, VEL_MIN, VEL_MIN, VEL_MIN, 1'b1);
        send_node(DEN_MAX, VEL_MAX, VEL_MAX, VEL_MAX, 1'b1);
        // Negative means and momenta must truncate toward zero.
        send_node(31'd3, 32'hFFFF_FFFD, 32'hFFFF_8000, 32'd1, 1'b0);
        send_node(31'd1, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'h0001_0000, 1'b1);
        // Densities equal to and around the reference.
        send_node(31'd65536, 32'h0001_0000, '0, '0, 1'b0);
        send_node(31'd65535, '0, 32'hFFFF_0000, '0, 1'b0);
        send_node(31'd65537, '0, '0, 32'h0000_8000, 1'b1);

        // Zero reference: smallest density stays zero; speed of exactly 5.0.
        wait_idle();
        write_reference('0);
        send_node(31'd5, 32'h0003_0000, 32'h0004_0000, '0, 1'b0);
        send_node(DEN_MAX, VEL_MIN, VEL_MAX, 32'd1, 1'b0);
        send_node(31'd200, 32'hFFFF_FFFF, '0, 32'h8000_0001, 1'b1);

        // Full-scale reference: largest density stays at the reference.
        wait_idle();
        write_reference(DEN_MAX);
        send_node(31'd10, 32'h0000_0001, 32'hFFFF_FFFF, '0, 1'b1);
        send_node(DEN_MAX, '0, '0, '0, 1'b0);
        send_node(31'd0, VEL_MAX, VEL_MIN, VEL_MAX, 1'b1);

        // Reference of 1.5, written between sets.
        wait_idle();
        write_reference(31'h0001_8000);
        send_node(31'h0001_8000, 32'h0000_0100, 32'h0000_0200, 32'h0000_0300, 1'b0);
        send_node(31'h0001_7FFF, 32'hFFFF_FF00, '0, '0, 1'b0);
        send_node(31'h0001_8001, '0, '0, 32'hFFFF_FFFF, 1'b1);

        // Random sets; register changes only once the long hold-off is over, so the
        // sender keeps offering nodes while the output is held.
        pressure_go = 1'b1;
        while (sent_items < ITEM_TARGET)
        begin
            if (pressure_done && ($urandom_range(0, 5) == 0))
            begin
                wait_idle();
                write_reference(pick_reference());
            end
            set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 48)
                                                  : $urandom_range(1, 12);
            for (n = 0; n < set_len; n++)
                send_node(pick_density(), pick_velocity(), pick_velocity(),
                          pick_velocity(), n == set_len - 1);
        end

        // Drain and let the block settle before the verdict.
        s_tvalid = 1'b0;
        while (pending_results != 0)
            @(negedge clk);
        repeat (400) @(negedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* flow_field_statistics_core.f */
hdl/ffs_pkg.sv
hdl/ffs_sqrt.sv
hdl/ffs_div.sv
hdl/flow_field_statistics_core.sv
hdl/ffs_checker.sv
tb/ffs_stats_checker.sv
tb/flow_field_statistics_core_tb.sv
